[hdl/ibar_pkg.sv]
package ibar_pkg;

  localparam int SENSORS      = 8;
  localparam int STOP_HOLD_MS = 1000;

  localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CNT_W  = $clog2(SENSORS + 1);
  // sum of up to eight bearings of -1280 to +1270 tenths
  localparam int SUM_W  = 15;
  localparam int MAG_W  = 14;
  localparam int STEP_W = $clog2(MAG_W + 1);

  localparam logic [9:0]         HALF_TURN   = 10'd675;
  localparam logic signed [15:0] SLOW_VEL    = 16'sd50;
  localparam logic signed [15:0] SLOW_NEG    = -16'sd50;
  localparam logic signed [12:0] HEADING_TOL = 13'sd30;
  localparam logic signed [12:0] HEADING_NEG = -13'sd30;
  localparam logic signed [12:0] WRAP_HI     = 13'sd1800;
  localparam logic signed [12:0] WRAP_LO     = -13'sd1800;
  localparam logic signed [12:0] FULL_TURN   = 13'sd3600;
  localparam logic [31:0]        HOLD_MS     = 32'(STOP_HOLD_MS);

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_POL  = 2'd2,
    MODE_RSVD = 2'd3
  } ibar_mode_e;

  typedef enum logic [1:0] {
    REQ_NONE     = 2'd0,
    REQ_EMPTY    = 2'd1,
    REQ_VEL_HOLD = 2'd2,
    REQ_VEL_HEAD = 2'd3
  } ibar_req_e;

  typedef enum logic [2:0] {
    REG_BACK_OFF_SPEED  = 3'd0,
    REG_BACK_OFF_TIME   = 3'd1,
    REG_TURN_TIME       = 3'd2,
    REG_SENSING_MODE    = 3'd3,
    REG_SENSOR_POLARITY = 3'd4,
    REG_FRONT_MASK      = 3'd5,
    REG_CYCLE_LIMITS    = 3'd6,
    REG_SENSOR_ANGLES   = 3'd7
  } ibar_reg_e;

  typedef struct packed {
    logic [10:0] back_off_speed;
    logic [15:0] back_off_time;
    logic [15:0] turn_time;
    ibar_mode_e  sensing_mode;
    logic [7:0]  sensor_polarity;
    logic [7:0]  front_mask;
    logic [63:0] cycle_limits;
    logic [63:0] sensor_angles;
  } ibar_cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [SENSORS-1:0] trig;
    logic               sense_en;
    logic signed [15:0] robot_velocity;
    logic signed [11:0] robot_heading;
  } ibar_work_t;

  typedef struct packed {
    ibar_req_e          request_kind;
    logic signed [11:0] velocity_cmd;
    logic signed [11:0] heading_cmd;
    logic               estop_pulse;
  } ibar_res_t;

endpackage

[hdl/ibar_if.sv]
interface ibar_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic [7:0]         sensor_bits;
  logic signed [15:0] robot_velocity;
  logic signed [11:0] robot_heading;

  modport source (output valid, output now_ms, output sensor_bits,
                  output robot_velocity, output robot_heading, input ready);
  modport sink   (input valid, input now_ms, input sensor_bits,
                  input robot_velocity, input robot_heading, output ready);
endinterface

interface ibar_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         request_kind;
  logic signed [11:0] velocity_cmd;
  logic signed [11:0] heading_cmd;
  logic               estop_pulse;

  modport source (output valid, output request_kind, output velocity_cmd,
                  output heading_cmd, output estop_pulse, input ready);
  modport sink   (input valid, input request_kind, input velocity_cmd,
                  input heading_cmd, input estop_pulse, output ready);
endinterface

[hdl/ir_bump_avoid_reflex_unit.sv]
// infrared bump-avoid reflex for a mobile robot base
//
// channels: in_i carries one control cycle per transaction (time stamp,
// raw table-sensor byte, measured velocity and heading); out_o returns
// exactly one motion request per input transaction, in order. both use
// valid/ready, a transaction moves on an edge where both are high.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (speed, times, sensing mode, polarity, front mask, limits, bearings);
// write only while no transaction is in flight.
//
// the back end answers at once while an escape phase is running or sensing
// is off; otherwise it walks the sensors one per cycle, and when the escape
// is triggered the averaging divider yields one quotient bit per cycle.
// the back end finishes an item before it pops another; a two-entry queue
// lets the front accept up to two more transactions meanwhile.
//
// reset: debounce counters go to 1, escape state clears, registers take
// their defaults. a stalled receiver holds the result in the output
// register; the back end waits there and the queue fills behind it.
module ir_bump_avoid_reflex_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ibar_in_if.sink     in_i,
  ibar_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import ibar_pkg::*;

  ibar_cfg_t  cfg_q;

  // queue between the classifying front and the executing back end
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  ibar_work_t work_in;
  ibar_work_t work_out;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.back_off_speed  <= '0;
      cfg_q.back_off_time   <= '0;
      cfg_q.turn_time       <= '0;
      cfg_q.sensing_mode    <= MODE_OFF;
      cfg_q.sensor_polarity <= '0;
      cfg_q.front_mask      <= '0;
      cfg_q.cycle_limits    <= 64'h0101_0101_0101_0101;
      cfg_q.sensor_angles   <= '0;
    end else if (cfg_we_i) begin
      unique case (ibar_reg_e'(cfg_idx_i))
        REG_BACK_OFF_SPEED:  cfg_q.back_off_speed  <= cfg_data_i[10:0];
        REG_BACK_OFF_TIME:   cfg_q.back_off_time   <= cfg_data_i[15:0];
        REG_TURN_TIME:       cfg_q.turn_time       <= cfg_data_i[15:0];
        REG_SENSING_MODE:    cfg_q.sensing_mode    <= ibar_mode_e'(cfg_data_i[1:0]);
        REG_SENSOR_POLARITY: cfg_q.sensor_polarity <= cfg_data_i[7:0];
        REG_FRONT_MASK:      cfg_q.front_mask      <= cfg_data_i[7:0];
        REG_CYCLE_LIMITS:    cfg_q.cycle_limits    <= cfg_data_i;
        REG_SENSOR_ANGLES:   cfg_q.sensor_angles   <= cfg_data_i;
      endcase
    end
  end

  // front: take the transaction, resolve trigger bits from the sensing mode
  ibar_front u_front (
    .in_i       (in_i),
    .mode_i     (cfg_q.sensing_mode),
    .polarity_i (cfg_q.sensor_polarity),
    .full_i     (full),
    .push_o     (push),
    .work_o     (work_in)
  );

  ibar_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (work_out)
  );

  // back: escape timing, debounce walk, averaging and output register
  ibar_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .work_i  (work_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[hdl/ibar_front.sv]
module ibar_front (
  ibar_in_if.sink              in_i,
  input  ibar_pkg::ibar_mode_e mode_i,
  input  logic [7:0]           polarity_i,
  input  logic                 full_i,
  output logic                 push_o,
  output ibar_pkg::ibar_work_t work_o
);
  import ibar_pkg::*;

  logic [SENSORS-1:0] trig;
  logic               sense_en;

  // which sensors see the table edge this cycle
  always_comb begin
    unique case (mode_i)
      MODE_LOW: begin
        trig     = ~in_i.sensor_bits[SENSORS-1:0];
        sense_en = 1'b1;
      end
      MODE_POL: begin
        trig     = in_i.sensor_bits[SENSORS-1:0] ^ polarity_i[SENSORS-1:0];
        sense_en = 1'b1;
      end
      MODE_OFF, MODE_RSVD: begin
        trig     = '0;
        sense_en = 1'b0;
      end
    endcase
  end

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  assign work_o.now_ms         = in_i.now_ms;
  assign work_o.trig           = trig;
  assign work_o.sense_en       = sense_en;
  assign work_o.robot_velocity = in_i.robot_velocity;
  assign work_o.robot_heading  = in_i.robot_heading;

endmodule

[hdl/ibar_fifo.sv]
module ibar_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ibar_pkg::ibar_work_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ibar_pkg::ibar_work_t data_o
);
  import ibar_pkg::*;

  ibar_work_t slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

[hdl/ibar_div.sv]
module ibar_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ibar_pkg::MAG_W-1:0] num_i,
  input  logic [ibar_pkg::CNT_W-1:0] den_i,
  output logic                       done_o,
  output logic [ibar_pkg::MAG_W-1:0] quot_o
);
  import ibar_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [MAG_W-1:0]  num_q;
  logic [MAG_W-1:0]  quot_q;
  logic [CNT_W-1:0]  den_q;
  logic [CNT_W:0]    rem_q;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[CNT_W-1:0], num_q[MAG_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[MAG_W-2:0], 1'b0};
      rem_q  <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_q <= {quot_q[MAG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !start_i && (step_q == STEP_W'(MAG_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/ibar_back.sv]
module ibar_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ibar_pkg::ibar_cfg_t  cfg_i,
  input  logic                 empty_i,
  input  ibar_pkg::ibar_work_t work_i,
  output logic                 pop_o,
  ibar_out_if.source           out_o
);
  import ibar_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_SCAN,
    ST_TALLY,
    ST_DIV,
    ST_ESC,
    ST_EMIT
  } state_e;

  function automatic logic signed [12:0] wrap_tenths(input logic signed [12:0] a);
    logic signed [12:0] r;
    r = a;
    if (a > WRAP_HI) begin
      r = a - FULL_TURN;
    end else if (a <= WRAP_LO) begin
      r = a + FULL_TURN;
    end
    return r;
  endfunction

  state_e                    state_q;
  ibar_work_t                item_q;
  logic                      escaping_q;
  logic signed [11:0]        esc_head_q;
  logic [31:0]               back_start_q;
  logic [31:0]               stopped_q;
  logic [7:0]                cnt_q [SENSORS];
  logic [IDX_W-1:0]          idx_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]          count_q;
  logic [31:0]               e_q;
  logic [31:0]               hold_q;
  logic                      dbig_q;
  logic                      div_start_q;
  ibar_res_t                 res_q;
  ibar_res_t                 out_q;
  logic                      out_valid_q;

  logic [7:0]                lim;
  logic signed [7:0]         ang;
  logic signed [SUM_W-1:0]   ang_ext;
  logic signed [SUM_W-1:0]   ang10;
  logic                      trig_bit;
  logic [7:0]                cur_cnt;
  logic                      fire;
  logic                      last_idx;
  logic signed [12:0]        dh;
  logic signed [12:0]        dw;
  logic                      dbig;
  logic [16:0]               win;
  logic [SUM_W-1:0]          sum_abs;
  logic [MAG_W-1:0]          num;
  logic                      div_done;
  logic [MAG_W-1:0]          quot;
  logic [9:0]                avg_m;
  logic                      neg;
  logic [9:0]                off_mag;
  logic signed [12:0]        off;
  logic signed [12:0]        hs;
  logic signed [11:0]        eh;
  logic signed [11:0]        neg_speed;
  logic                      vel_fast;
  logic                      vel_slow;
  logic                      have_hits;
  logic                      emit_go;

  always_comb begin
    lim      = cfg_i.cycle_limits[idx_q*8 +: 8];
    ang      = $signed(cfg_i.sensor_angles[idx_q*8 +: 8]);
    ang_ext  = SUM_W'(ang);
    ang10    = (ang_ext <<< 3) + (ang_ext <<< 1);
    trig_bit = item_q.trig[idx_q];
    cur_cnt  = cnt_q[idx_q];
    fire     = trig_bit && !(cur_cnt < lim);
    last_idx = (idx_q == IDX_W'(SENSORS - 1));

    dh   = 13'(item_q.robot_heading) - 13'(esc_head_q);
    dw   = wrap_tenths(dh);
    dbig = (dw > HEADING_TOL) || (dw < HEADING_NEG);
    win  = 17'(cfg_i.back_off_time) + 17'(cfg_i.turn_time);

    sum_abs = sum_q[SUM_W-1] ? (-sum_q) : sum_q;
    num     = MAG_W'(sum_abs) + MAG_W'(count_q >> 1);

    // clamp the rounded average, then offset away from it
    avg_m   = (quot > MAG_W'(HALF_TURN)) ? HALF_TURN : quot[9:0];
    neg     = sum_q[SUM_W-1] && (avg_m != 10'd0);
    off_mag = HALF_TURN - avg_m;
    off     = neg ? -$signed({3'b000, off_mag}) : $signed({3'b000, off_mag});
    hs      = 13'(item_q.robot_heading) + off;
    eh      = 12'(wrap_tenths(hs));

    neg_speed = 12'sd0 - $signed({1'b0, cfg_i.back_off_speed});
    vel_fast  = item_q.robot_velocity > SLOW_VEL;
    vel_slow  = (item_q.robot_velocity > SLOW_NEG) && (item_q.robot_velocity < SLOW_VEL);
    have_hits = (count_q != '0);
  end

  assign pop_o   = (state_q == ST_IDLE) && !empty_i;
  // output register free or emptying this cycle
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  ibar_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num),
    .den_i   (count_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      escaping_q   <= 1'b0;
      esc_head_q   <= '0;
      back_start_q <= '0;
      stopped_q    <= '0;
      for (int i = 0; i < SENSORS; i++) begin
        cnt_q[i] <= 8'd1;
      end
      idx_q        <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      e_q          <= '0;
      hold_q       <= '0;
      dbig_q       <= 1'b0;
      div_start_q  <= 1'b0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      div_start_q <= (state_q == ST_TALLY) && have_hits && vel_fast;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            item_q  <= work_i;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          e_q     <= item_q.now_ms - back_start_q;
          hold_q  <= item_q.now_ms - stopped_q;
          dbig_q  <= dbig;
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          priority if (escaping_q && (e_q < 32'(cfg_i.back_off_time))) begin
            res_q   <= '{REQ_VEL_HOLD, neg_speed, 12'sd0, 1'b0};
            state_q <= ST_EMIT;
          end else if (escaping_q && (e_q < 32'(win)) && dbig_q) begin
            res_q   <= '{REQ_VEL_HEAD, 12'sd0, esc_head_q, 1'b0};
            state_q <= ST_EMIT;
          end else if (escaping_q && (hold_q < HOLD_MS)) begin
            res_q   <= '{REQ_VEL_HOLD, 12'sd0, 12'sd0, 1'b0};
            state_q <= ST_EMIT;
          end else begin
            escaping_q <= 1'b0;
            if (item_q.sense_en) begin
              idx_q   <= '0;
              sum_q   <= '0;
              count_q <= '0;
              state_q <= ST_SCAN;
            end else begin
              res_q   <= '{REQ_NONE, 12'sd0, 12'sd0, 1'b0};
              state_q <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          // debounce one sensor per cycle
          if (trig_bit && (cur_cnt < lim)) begin
            cnt_q[idx_q] <= cur_cnt + 8'd1;
          end else begin
            cnt_q[idx_q] <= 8'd1;
          end
          if (fire && cfg_i.front_mask[idx_q]) begin
            sum_q   <= sum_q + ang10;
            count_q <= count_q + CNT_W'(1);
          end
          if (last_idx) begin
            state_q <= ST_TALLY;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_TALLY: begin
          priority if (have_hits && vel_fast) begin
            state_q <= ST_DIV;
          end else if (have_hits && vel_slow) begin
            stopped_q <= item_q.now_ms;
            res_q     <= '{REQ_EMPTY, 12'sd0, 12'sd0, 1'b0};
            state_q   <= ST_EMIT;
          end else begin
            res_q   <= '{REQ_NONE, 12'sd0, 12'sd0, 1'b0};
            state_q <= ST_EMIT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_ESC;
          end
        end
        ST_ESC: begin
          esc_head_q   <= eh;
          back_start_q <= item_q.now_ms;
          escaping_q   <= 1'b1;
          res_q        <= '{REQ_VEL_HEAD, neg_speed, eh, 1'b1};
          state_q      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.request_kind = out_q.request_kind;
  assign out_o.velocity_cmd = out_q.velocity_cmd;
  assign out_o.heading_cmd  = out_q.heading_cmd;
  assign out_o.estop_pulse  = out_q.estop_pulse;

endmodule

[hdl/ibar_checker.sv]
module ibar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  request_kind_i,
  input logic [11:0] velocity_cmd_i,
  input logic [11:0] heading_cmd_i,
  input logic        estop_pulse_i
);
  import ibar_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(request_kind_i) &&
      $stable(velocity_cmd_i) && $stable(heading_cmd_i) && $stable(estop_pulse_i))
    else $error("result changed while stalled");

  a_estop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && estop_pulse_i |-> request_kind_i == REQ_VEL_HEAD)
    else $error("estop without heading request");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (request_kind_i == REQ_NONE || request_kind_i == REQ_EMPTY) |->
      velocity_cmd_i == 12'd0 && heading_cmd_i == 12'd0 && !estop_pulse_i)
    else $error("idle request carries motion");

  a_hold_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && request_kind_i == REQ_VEL_HOLD |->
      heading_cmd_i == 12'd0 && !estop_pulse_i)
    else $error("hold request carries heading");

  a_estop_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && estop_pulse_i |-> velocity_cmd_i[11] || velocity_cmd_i == 12'd0)
    else $error("estop with forward velocity");

endmodule

bind ir_bump_avoid_reflex_unit ibar_checker u_ibar_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .request_kind_i (out_o.request_kind),
  .velocity_cmd_i (out_o.velocity_cmd),
  .heading_cmd_i  (out_o.heading_cmd),
  .estop_pulse_i  (out_o.estop_pulse)
);

[bench/tb_ir_bump_avoid_reflex_unit.sv]
`timescale 1ns / 1ps

module tb_ir_bump_avoid_reflex_unit;
  import ibar_pkg::*;

  // bench timing
  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 10;
  // quiet margin after the last request before a register write
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PCT      = 25;
  localparam int NOISE_PCT     = 5;

  // reflex arithmetic, angles in tenths of a degree
  localparam int HALF_CIRCLE    = 1800;
  localparam int FULL_CIRCLE    = 3600;
  localparam int ESC_RANGE      = 675;
  localparam int SLOW_LIMIT     = 50;
  localparam int HEAD_TOL       = 30;
  localparam int TENTHS_PER_DEG = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  ibar_in_if  in_if ();
  ibar_out_if out_if ();

  ir_bump_avoid_reflex_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the reflex: settings, debounce counters and escape state
  ibar_cfg_t   shadow_cfg;
  logic [7:0]  bounce_count [SENSORS];
  logic        in_escape;
  int          escape_dir;
  logic [31:0] backoff_start;
  logic [31:0] stop_mark;

  // motion requests still owed by the block, oldest first
  ibar_res_t   expected_requests [$];
  ibar_res_t   oldest_request;

  int errors               = 0;
  int cycles_sent          = 0;
  int results_seen         = 0;
  int escapes_predicted    = 0;
  int slow_stops_predicted = 0;
  int cycle_count          = 0;

  // stimulus state
  logic [31:0] clock_ms       = '0;
  logic [7:0]  sensor_pattern = '0;
  logic        tx_calm        = 1'b0;
  // receiver controls, set on the falling edge by set_receiver
  logic        rx_calm        = 1'b0;
  int          hold_req       = 0;
  int          hold_left      = 0;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF_NS clk_i = ~clk_i;
  end

  // give up if the block stops moving
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d requests outstanding", cycle_count,
             expected_requests.size());
    $display("tb_ir_bump_avoid_reflex_unit failed");
    $finish;
  end

  // heading difference folded into (-180, 180] degrees
  function automatic int fold_heading(input int a);
    if (a > HALF_CIRCLE) return a - FULL_CIRCLE;
    if (a <= -HALF_CIRCLE) return a + FULL_CIRCLE;
    return a;
  endfunction

  task automatic reset_shadow();
    shadow_cfg = '0;
    shadow_cfg.sensing_mode = MODE_OFF;
    shadow_cfg.cycle_limits = 64'h0101_0101_0101_0101;
    for (int i = 0; i < SENSORS; i++) bounce_count[i] = 8'd1;
    in_escape     = 1'b0;
    escape_dir    = 0;
    backoff_start = '0;
    stop_mark     = '0;
  endtask

  // one control cycle of the reflex: updates the shadow state, returns the request
  function automatic ibar_res_t predict_request(input logic [31:0] now,
                                                input logic [7:0] bits,
                                                input logic signed [15:0] vel_in,
                                                input logic signed [11:0] head_in);
    ibar_res_t         r;
    logic [31:0]       elapsed;
    logic [7:0]        trig;
    logic [7:0]        lim;
    logic signed [7:0] bearing;
    int                vel;
    int                head;
    int                err;
    int                sum;
    int                hits;
    int                mag;
    int                avg;
    int                off;
    r = '0;
    r.request_kind = REQ_NONE;
    vel  = vel_in;
    head = head_in;
    sum  = 0;
    hits = 0;

    // running escape: back off, then turn, then hold still
    if (in_escape) begin
      elapsed = now - backoff_start;
      if (elapsed < 32'(shadow_cfg.back_off_time)) begin
        r.request_kind = REQ_VEL_HOLD;
        r.velocity_cmd = 12'(-int'(shadow_cfg.back_off_speed));
        return r;
      end
      if (elapsed < 32'(shadow_cfg.back_off_time) + 32'(shadow_cfg.turn_time)) begin
        err = fold_heading(head - escape_dir);
        if (err > HEAD_TOL || err < -HEAD_TOL) begin
          r.request_kind = REQ_VEL_HEAD;
          r.heading_cmd  = 12'(escape_dir);
          return r;
        end
      end
      if (now - stop_mark < 32'(STOP_HOLD_MS)) begin
        r.request_kind = REQ_VEL_HOLD;
        return r;
      end
      // escape over, this cycle still senses
      in_escape = 1'b0;
    end

    case (shadow_cfg.sensing_mode)
      MODE_LOW: trig = ~bits;
      MODE_POL: trig = bits ^ shadow_cfg.sensor_polarity;
      default:  return r;
    endcase

    for (int i = 0; i < SENSORS; i++) begin
      if (trig[i]) begin
        lim = shadow_cfg.cycle_limits[8*i +: 8];
        if (bounce_count[i] < lim) begin
          bounce_count[i] = bounce_count[i] + 8'd1;
        end else begin
          bounce_count[i] = 8'd1;
          if (shadow_cfg.front_mask[i]) begin
            bearing = shadow_cfg.sensor_angles[8*i +: 8];
            sum += int'(bearing) * TENTHS_PER_DEG;
            hits++;
          end
        end
      end else begin
        bounce_count[i] = 8'd1;
      end
    end

    if (hits > 0 && vel > SLOW_LIMIT) begin
      // rounded average, ties away from zero, then clamped
      mag = (sum < 0) ? -sum : sum;
      avg = (mag + hits / 2) / hits;
      if (sum < 0) avg = -avg;
      if (avg > ESC_RANGE) avg = ESC_RANGE;
      else if (avg < -ESC_RANGE) avg = -ESC_RANGE;
      off = (avg < 0) ? -(ESC_RANGE + avg) : ESC_RANGE - avg;
      escape_dir    = fold_heading(head + off);
      backoff_start = now;
      in_escape     = 1'b1;
      escapes_predicted++;
      r.request_kind = REQ_VEL_HEAD;
      r.velocity_cmd = 12'(-int'(shadow_cfg.back_off_speed));
      r.heading_cmd  = 12'(escape_dir);
      r.estop_pulse  = 1'b1;
      return r;
    end
    if (hits > 0 && vel > -SLOW_LIMIT && vel < SLOW_LIMIT) begin
      stop_mark = now;
      slow_stops_predicted++;
      r.request_kind = REQ_EMPTY;
    end
    return r;
  endfunction

  // receiver: long hold-offs on request, otherwise random stalls or always ready
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (rx_calm) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result checker: every transaction on out_o against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_requests.size() == 0) begin
        $error("request with nothing pending: kind %0d velocity %0d heading %0d estop %0b",
               out_if.request_kind, out_if.velocity_cmd, out_if.heading_cmd,
               out_if.estop_pulse);
        errors++;
      end else begin
        oldest_request = expected_requests.pop_front();
        if (out_if.request_kind !== oldest_request.request_kind) begin
          $error("request_kind expected %0d actual %0d", oldest_request.request_kind,
                 out_if.request_kind);
          errors++;
        end
        if (out_if.velocity_cmd !== oldest_request.velocity_cmd) begin
          $error("velocity_cmd expected %0d actual %0d", oldest_request.velocity_cmd,
                 out_if.velocity_cmd);
          errors++;
        end
        if (out_if.heading_cmd !== oldest_request.heading_cmd) begin
          $error("heading_cmd expected %0d actual %0d", oldest_request.heading_cmd,
                 out_if.heading_cmd);
          errors++;
        end
        if (out_if.estop_pulse !== oldest_request.estop_pulse) begin
          $error("estop_pulse expected %0b actual %0b", oldest_request.estop_pulse,
                 out_if.estop_pulse);
          errors++;
        end
      end
    end
  end

  // offer one control cycle; valid stays up so back-to-back transactions need no gap
  task automatic offer_cycle(input logic [31:0] now, input logic [7:0] bits,
                             input logic signed [15:0] vel, input logic signed [11:0] head);
    ibar_res_t predicted;
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.now_ms         <= now;
    in_if.sensor_bits    <= bits;
    in_if.robot_velocity <= vel;
    in_if.robot_heading  <= head;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted         = predict_request(now, bits, vel, head);
    expected_requests = {expected_requests, predicted};
    cycles_sent++;
  endtask

  // stop offering, wait for every owed request, then let the back end go quiet
  task automatic drain_requests();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_requests.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all eight registers, junk above each field to show it is ignored
  task automatic apply_settings(input ibar_cfg_t c);
    logic [63:0] word;
    ibar_reg_e   idx;
    for (int k = 0; k < 8; k++) begin
      idx  = ibar_reg_e'(k);
      word = {$urandom, $urandom};
      case (idx)
        REG_BACK_OFF_SPEED:  word[10:0] = c.back_off_speed;
        REG_BACK_OFF_TIME:   word[15:0] = c.back_off_time;
        REG_TURN_TIME:       word[15:0] = c.turn_time;
        REG_SENSING_MODE:    word[1:0]  = c.sensing_mode;
        REG_SENSOR_POLARITY: word[7:0]  = c.sensor_polarity;
        REG_FRONT_MASK:      word[7:0]  = c.front_mask;
        REG_CYCLE_LIMITS:    word       = c.cycle_limits;
        default:             word       = c.sensor_angles;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= word;
      @(posedge clk_i);
    end
    shadow_cfg = c;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver controls change on the falling edge, away from its sampling
  task automatic set_receiver(input int hold, input logic calm);
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    hold_req = hold;
    rx_calm  = calm;
    @(posedge clk_i);
  endtask

  function automatic ibar_cfg_t make_settings(input logic [10:0] speed,
                                              input logic [15:0] backoff_ms,
                                              input logic [15:0] turn_ms,
                                              input ibar_mode_e mode, input logic [7:0] pol,
                                              input logic [7:0] front,
                                              input logic [63:0] limits,
                                              input logic [63:0] angles);
    ibar_cfg_t c;
    c.back_off_speed  = speed;
    c.back_off_time   = backoff_ms;
    c.turn_time       = turn_ms;
    c.sensing_mode    = mode;
    c.sensor_polarity = pol;
    c.front_mask      = front;
    c.cycle_limits    = limits;
    c.sensor_angles   = angles;
    return c;
  endfunction

  // short escape timings and short debounce so escapes come often
  function automatic ibar_cfg_t random_settings();
    ibar_cfg_t c;
    c.back_off_speed  = 11'($urandom_range(2000));
    c.back_off_time   = 16'($urandom_range(400));
    c.turn_time       = 16'($urandom_range(600));
    c.sensing_mode    = ibar_mode_e'($urandom_range(2, 1));
    c.sensor_polarity = 8'($urandom);
    c.front_mask      = 8'($urandom);
    for (int i = 0; i < SENSORS; i++) c.cycle_limits[8*i +: 8] = 8'($urandom_range(3));
    c.sensor_angles   = {$urandom, $urandom};
    return c;
  endfunction

  // a plausible control cycle: time moves forward, sensor patterns persist,
  // heading sometimes lands near the escape heading so the turn can finish
  task automatic offer_random(input int max_step, input int churn_pct);
    logic [7:0]         bits;
    logic signed [15:0] vel;
    logic signed [11:0] head;
    int                 pick;
    int                 h;
    if ($urandom_range(99) < NOISE_PCT) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(max_step, 1);
    if ($urandom_range(99) < churn_pct) sensor_pattern = 8'($urandom);
    bits = ($urandom_range(99) < NOISE_PCT) ? 8'($urandom) : sensor_pattern;
    pick = $urandom_range(99);
    if (pick < 40) begin
      vel = 16'($urandom_range(1500, SLOW_LIMIT + 1));
    end else if (pick < 70) begin
      vel = 16'(int'($urandom_range(2 * SLOW_LIMIT - 2)) - (SLOW_LIMIT - 1));
    end else if (pick < 80) begin
      case ($urandom_range(4))
        0:       vel = 16'(SLOW_LIMIT);
        1:       vel = 16'(-SLOW_LIMIT);
        2:       vel = 16'(SLOW_LIMIT + 1);
        3:       vel = 16'(-SLOW_LIMIT - 1);
        default: vel = 16'(SLOW_LIMIT - 1);
      endcase
    end else begin
      vel = 16'($urandom);
    end
    if (in_escape && $urandom_range(99) < 40) begin
      h = escape_dir + int'($urandom_range(4 * HEAD_TOL / 3 * 2)) - 4 * HEAD_TOL / 3;
    end else begin
      h = int'($urandom_range(FULL_CIRCLE)) - HALF_CIRCLE;
    end
    if (h > HALF_CIRCLE) h -= FULL_CIRCLE;
    if (h < -HALF_CIRCLE) h += FULL_CIRCLE;
    head = 12'(h);
    offer_cycle(clock_ms, bits, vel, head);
  endtask

  task automatic run_random(input int n, input int max_step, input int churn_pct);
    repeat (n) offer_random(max_step, churn_pct);
  endtask

  // ---------------------------------------------------------------- tests

  // registers untouched: sensing off, nothing but REQ_NONE answers
  task automatic test_power_on_defaults();
    offer_cycle(32'd5, 8'h00, 16'sd600, 12'sd0);
    offer_cycle(32'd6, 8'hFF, -16'sd600, 12'sd0);
    drain_requests();
  endtask

  // active-low port: slow stop, velocity edges, debounce, every escape phase,
  // rounding and clamping of the bearing average, heading and time wrap
  task automatic test_active_low_escape();
    // sensor 7 fires on the third triggered offer in a row, sensor 6 on every triggered offer
    apply_settings(make_settings(11'd2000, 16'd100, 16'd200, MODE_LOW, 8'h00, 8'hFF,
                                 64'h0300_0101_0101_0101, 64'h5AFF_0100_D32D_807F));
    offer_cycle(32'd1000, 8'hFF, 16'sd500, 12'sd0);        // nothing triggered
    offer_cycle(32'd1010, 8'hFE, 16'sd20, 12'sd100);       // slow with contributor
    offer_cycle(32'd1020, 8'hFE, 16'sd50, 12'sd100);       // exactly at the speed edge
    offer_cycle(32'd1030, 8'hFC, -16'sd50, 12'sd100);      // exactly at the reverse edge
    offer_cycle(32'd1040, 8'h7F, 16'sd100, 12'sd0);        // debounce counting up
    offer_cycle(32'd1050, 8'h7F, 16'sd100, 12'sd0);
    offer_cycle(32'd1060, 8'h7F, 16'sd100, 12'sd1800);     // fires, bearing clamped high
    offer_cycle(32'd1100, 8'h00, 16'sd900, 12'sd1800);     // backing off
    offer_cycle(32'd1200, 8'h00, 16'sd900, 12'sd0);        // turning
    offer_cycle(32'd1250, 8'h00, 16'sd900, -12'sd1790);    // on heading, stop hold
    offer_cycle(32'd2100, 8'hFC, 16'sd800, -12'sd1500);    // escape ends, sensing resumes
    offer_cycle(32'd2150, 8'hFF, 16'sd0, 12'sd0);
    offer_cycle(32'd2500, 8'hF5, 16'sd300, -12'sd1800);    // bearing clamped low
    offer_cycle(32'hFFFF_FFF0, 8'hBF, 16'sd200, 12'sd450); // zero limit fires
    offer_cycle(32'h0000_0020, 8'hFF, 16'sd200, 12'sd0);   // elapsed across the time wrap
    offer_cycle(32'h0000_0400, 8'hE0, 16'sd1200, 12'sd700);
    drain_requests();
  endtask

  // per-sensor polarity, rear sensors fire but add no bearing
  task automatic test_polarity_mode();
    apply_settings(make_settings(11'd700, 16'd10, 16'd0, MODE_POL, 8'hA5, 8'h0F,
                                 64'h0202_0202_0202_0202, 64'h1020_3040_F0E0_D0C0));
    offer_cycle(32'd3000, 8'hA5, 16'sd100, 12'sd0);
    offer_cycle(32'd3010, 8'h5A, 16'sd100, 12'sd0);
    offer_cycle(32'd3020, 8'h5A, 16'sd100, -12'sd900);
    drain_requests();
  endtask

  // sensing off and the reserved mode both ignore the port
  task automatic test_off_and_unused_modes();
    apply_settings(make_settings(11'd0, 16'hFFFF, 16'hFFFF, MODE_OFF, 8'hFF, 8'h00,
                                 64'h0, 64'h7F7F_7F7F_7F7F_7F7F));
    offer_cycle(32'd4000, 8'h00, 16'sd900, 12'sd0);
    drain_requests();
    apply_settings(make_settings(11'd0, 16'hFFFF, 16'hFFFF, MODE_RSVD, 8'hFF, 8'hFF,
                                 64'h0, 64'h7F7F_7F7F_7F7F_7F7F));
    offer_cycle(32'd4010, 8'h00, 16'sd900, 12'sd0);
    drain_requests();
  endtask

  // everyday traffic, with the sender pausing halfway until the block is empty
  task automatic test_typical_traffic();
    ibar_cfg_t c;
    c = random_settings();
    c.back_off_speed = 11'd1500;
    c.back_off_time  = 16'd150;
    c.turn_time      = 16'd250;
    c.sensing_mode   = MODE_LOW;
    c.front_mask     = 8'hFF;
    apply_settings(c);
    clock_ms = $urandom;
    run_random(150, 80, 30);
    drain_requests();
    run_random(150, 80, 30);
    drain_requests();
  endtask

  // receiver holds off long enough for the queue to fill and stall the input
  task automatic test_backpressure();
    ibar_cfg_t c;
    c = random_settings();
    c.sensing_mode  = MODE_POL;
    c.back_off_time = 16'd80;
    c.turn_time     = 16'd200;
    apply_settings(c);
    set_receiver(300, 1'b0);
    run_random(250, 80, 30);
    drain_requests();
  endtask

  // longest escape times, immediate debounce, extreme bearings
  task automatic test_extreme_timing();
    apply_settings(make_settings(11'd2000, 16'hFFFF, 16'hFFFF, MODE_LOW, 8'h00, 8'hFF,
                                 64'h0, 64'h7F80_7F80_7F80_7F80));
    run_random(100, 30000, 30);
    drain_requests();
  endtask

  // no back-off or turn time and the longest debounce on half the sensors
  task automatic test_long_debounce();
    apply_settings(make_settings(11'd0, 16'd0, 16'd0, MODE_POL, 8'hFF, 8'hFF,
                                 64'hFF01_FF01_FF01_FF01, {$urandom, $urandom}));
    run_random(150, 60, 2);
    drain_requests();
  endtask

  // random settings, first without any idling on either side
  task automatic test_random_settings();
    apply_settings(random_settings());
    tx_calm = 1'b1;
    set_receiver(0, 1'b1);
    run_random(125, 80, 30);
    drain_requests();
    tx_calm = 1'b0;
    set_receiver(0, 1'b0);
    apply_settings(random_settings());
    run_random(125, 80, 30);
    drain_requests();
  endtask

  initial begin : main
    in_if.valid          = 1'b0;
    in_if.now_ms         = '0;
    in_if.sensor_bits    = '0;
    in_if.robot_velocity = '0;
    in_if.robot_heading  = '0;
    out_if.ready         = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_BACK_OFF_SPEED;
    cfg_data_i           = '0;
    rst_ni               = 1'b0;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_defaults();
    test_active_low_escape();
    test_polarity_mode();
    test_off_and_unused_modes();
    test_typical_traffic();
    test_backpressure();
    test_extreme_timing();
    test_long_debounce();
    test_random_settings();

    $display("sent %0d control cycles over directed and random settings: %0d escapes, %0d slow stops",
             cycles_sent, escapes_predicted, slow_stops_predicted);
    $display("checked %0d motion requests, %0d mismatches", results_seen, errors);
    if (errors == 0 && expected_requests.size() == 0) begin
      $display("tb_ir_bump_avoid_reflex_unit passed");
    end else begin
      $display("tb_ir_bump_avoid_reflex_unit failed");
    end
    $finish;
  end

endmodule
